### sv/hsbr_pkg.sv
// Shared types, constants and helpers for the HTTP single byte-range parser.
// No dependencies; the top level, the scanner and the finisher import this package.
package hsbr_pkg;

   localparam int unsigned PREFIX_LEN = 6;
   localparam int unsigned UNIT_LEN   = 5;
   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned COUNT_W    = 3;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_UNSAT = 2'd1,
      STATUS_MULTI = 2'd2
   } hsbr_status_type;

   // Parse state of one complete header, handed from the scanner to the finisher.
   typedef struct packed {
      logic               prefix_done;
      logic               invalid_seen;
      logic               comma_seen;
      logic               seen_dash;
      logic               first_present;
      logic               last_present;
      logic [VALUE_W-1:0] first_value;
      logic [VALUE_W-1:0] last_value;
   } hsbr_snap_type;

   typedef struct packed {
      hsbr_status_type    status;
      logic [VALUE_W-1:0] range_first;
      logic [VALUE_W-1:0] range_last;
   } hsbr_result_type;

   // Lower-case letters of the unit name "bytes".
   function automatic logic [7:0] unit_char(input logic [COUNT_W-1:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h62;
         3'd1:    c = 8'h79;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h65;
         3'd4:    c = 8'h73;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### sv/hsbr_req_if.sv
// Request channel of the byte-range parser: one header character per beat.
// Uses nothing outside this file.
interface hsbr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

### sv/hsbr_rsp_if.sv
// Response channel of the byte-range parser: one parsed range per beat.
// Uses nothing outside this file.
interface hsbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] range_first;
   logic [63:0] range_last;

   modport source (output valid, output status, output range_first, output range_last,
                   input ready);
   modport sink   (input valid, input status, input range_first, input range_last,
                   output ready);
endinterface

### sv/http_single_byte_range_parser.sv
// Top level of the HTTP single byte-range parser.
// Depends on hsbr_pkg, hsbr_req_if, hsbr_rsp_if, hsbr_scan and hsbr_finish.
//
// Usage:
//   req carries one character of a Range header per beat, with last set on
//   the final character. rsp gives one beat per header: status (ok, range not
//   satisfiable, multiple ranges), and the first and last byte offsets, which
//   are zero unless the status is ok. csr_wr_en / csr_wr_data write the file
//   size, which is kept across headers; write it only while the block is idle.
//   The scan state is registered in the decision stage, the result in the
//   response register. One character per cycle (back-to-back headers)
//   while req.ready is high; the scanner's shift-add by ten is combinational.
//   The decision stage holds one finished header and the response register
//   another, so the block keeps taking characters while a response waits.
//   When the receiver stalls with both of those full, req.ready drops until
//   the response beat is taken.
//   Reset clears the scan state, both stages and the file size (to zero).
module http_single_byte_range_parser (
   input  logic        clock,
   input  logic        reset,
   hsbr_req_if.sink    req,
   hsbr_rsp_if.source  rsp,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);
   import hsbr_pkg::*;

   logic [VALUE_W-1:0] resource_size_ff;
   logic               fin_valid_ff, fin_valid_in;
   hsbr_snap_type      fin_snap_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   hsbr_result_type    rsp_data_ff;

   hsbr_snap_type      scan_snap;
   hsbr_result_type    fin_result;
   logic               take;
   logic               out_free;
   logic               fin_free;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign fin_free  = !fin_valid_ff || out_free;
   assign req.ready = fin_free;
   assign take      = req.valid && fin_free;

   hsbr_scan u_scan (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .ch    (req.ch),
      .last  (req.last),
      .snap  (scan_snap)
   );

   hsbr_finish u_finish (
      .snap          (fin_snap_ff),
      .resource_size (resource_size_ff),
      .result        (fin_result)
   );

   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (take && req.last) begin
         fin_valid_in = 1'b1;
      end else if (out_free) begin
         fin_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fin_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resource_size_ff <= '0;
         fin_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            resource_size_ff <= csr_wr_data;
         end
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req.last) begin
         fin_snap_ff <= scan_snap;
      end
      if (fin_valid_ff && out_free) begin
         rsp_data_ff <= fin_result;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_data_ff.status;
   assign rsp.range_first = rsp_data_ff.range_first;
   assign rsp.range_last  = rsp_data_ff.range_last;

   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != STATUS_OK
         |-> rsp_data_ff.range_first == '0 && rsp_data_ff.range_last == '0)
      else $error("failed response carries a nonzero range");

   a_ok_in_file: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == STATUS_OK
         |-> rsp_data_ff.range_first <= rsp_data_ff.range_last
             && rsp_data_ff.range_last < resource_size_ff)
      else $error("ok response range lies outside the file");

   a_fin_held: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && !out_free |=> fin_valid_ff && $stable(fin_snap_ff))
      else $error("pending header lost while the response stage was full");

endmodule

### sv/hsbr_scan.sv
// Character scanner: checks the "bytes=" prefix and accumulates the two numbers.
// Depends on hsbr_pkg.
module hsbr_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            ch,
   input  logic                  last,
   output hsbr_pkg::hsbr_snap_type snap
);
   import hsbr_pkg::*;

   logic [COUNT_W-1:0] prefix_count_ff, prefix_count_in;
   logic               prefix_ok_ff, prefix_ok_in;
   logic               seen_dash_ff, seen_dash_in;
   logic               invalid_seen_ff, invalid_seen_in;
   logic               comma_seen_ff, comma_seen_in;
   logic [VALUE_W-1:0] first_value_ff, first_value_in;
   logic               first_present_ff, first_present_in;
   logic [VALUE_W-1:0] last_value_ff, last_value_in;
   logic               last_present_ff, last_present_in;

   logic [7:0]         lower_ch;
   logic               is_digit;
   logic [VALUE_W-1:0] acc;
   logic [VALUE_W+3:0] acc_next;
   logic               acc_ovf;

   assign lower_ch = (ch >= CH_UP_A && ch <= CH_UP_Z) ? (ch | CASE_BIT) : ch;
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign acc      = seen_dash_ff ? last_value_ff : first_value_ff;

   // acc * 10 + digit, with four spare bits to catch 64-bit overflow.
   assign acc_next = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
                   + {{VALUE_W{1'b0}}, 4'(ch - CH_ZERO)};
   assign acc_ovf  = |acc_next[VALUE_W+3:VALUE_W];

   always_comb begin
      prefix_count_in  = prefix_count_ff;
      prefix_ok_in     = prefix_ok_ff;
      seen_dash_in     = seen_dash_ff;
      invalid_seen_in  = invalid_seen_ff;
      comma_seen_in    = comma_seen_ff;
      first_value_in   = first_value_ff;
      first_present_in = first_present_ff;
      last_value_in    = last_value_ff;
      last_present_in  = last_present_ff;

      if (ch == CH_COMMA) begin
         comma_seen_in = 1'b1;
      end
      if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF) begin
         invalid_seen_in = 1'b1;
      end

      priority if (prefix_count_ff < COUNT_W'(PREFIX_LEN)) begin
         if (prefix_count_ff < COUNT_W'(UNIT_LEN)) begin
            if (lower_ch != unit_char(prefix_count_ff)) begin
               prefix_ok_in = 1'b0;
            end
         end else if (ch != CH_EQUAL) begin
            prefix_ok_in = 1'b0;
         end
         prefix_count_in = prefix_count_ff + 1'b1;
      end else if (ch == CH_DASH) begin
         if (seen_dash_ff) begin
            invalid_seen_in = 1'b1;
         end
         seen_dash_in = 1'b1;
      end else if (is_digit) begin
         if (!seen_dash_ff) begin
            first_present_in = 1'b1;
            if (!invalid_seen_ff) begin
               if (acc_ovf) invalid_seen_in = 1'b1;
               else         first_value_in  = acc_next[VALUE_W-1:0];
            end
         end else begin
            last_present_in = 1'b1;
            if (!invalid_seen_ff) begin
               if (acc_ovf) invalid_seen_in = 1'b1;
               else         last_value_in   = acc_next[VALUE_W-1:0];
            end
         end
      end else begin
         invalid_seen_in = 1'b1;
      end
   end

   // The finisher sees the state as it stands after the final character.
   always_comb begin
      snap.prefix_done   = prefix_ok_in && (prefix_count_in == COUNT_W'(PREFIX_LEN));
      snap.invalid_seen  = invalid_seen_in;
      snap.comma_seen    = comma_seen_in;
      snap.seen_dash     = seen_dash_in;
      snap.first_present = first_present_in;
      snap.last_present  = last_present_in;
      snap.first_value   = first_value_in;
      snap.last_value    = last_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last)) begin
         prefix_count_ff  <= '0;
         prefix_ok_ff     <= 1'b1;
         seen_dash_ff     <= 1'b0;
         invalid_seen_ff  <= 1'b0;
         comma_seen_ff    <= 1'b0;
         first_value_ff   <= '0;
         first_present_ff <= 1'b0;
         last_value_ff    <= '0;
         last_present_ff  <= 1'b0;
      end else if (take) begin
         prefix_count_ff  <= prefix_count_in;
         prefix_ok_ff     <= prefix_ok_in;
         seen_dash_ff     <= seen_dash_in;
         invalid_seen_ff  <= invalid_seen_in;
         comma_seen_ff    <= comma_seen_in;
         first_value_ff   <= first_value_in;
         first_present_ff <= first_present_in;
         last_value_ff    <= last_value_in;
         last_present_ff  <= last_present_in;
      end
   end

   // A closing beat leaves the scanner ready for a fresh header.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      take && last |=> prefix_count_ff == '0 && prefix_ok_ff && !seen_dash_ff
                       && !comma_seen_ff && !invalid_seen_ff)
      else $error("scanner state not cleared after final beat");

endmodule

### sv/hsbr_finish.sv
// Final decision for one header: status and clamped range from the scan state.
// Depends on hsbr_pkg.
module hsbr_finish (
   input  hsbr_pkg::hsbr_snap_type   snap,
   input  logic [63:0]               resource_size,
   output hsbr_pkg::hsbr_result_type result
);
   import hsbr_pkg::*;

   logic               first_ge_size;
   logic               last_ge_size;
   logic               last_lt_first;
   logic [VALUE_W-1:0] size_minus_one;
   logic [VALUE_W-1:0] size_minus_last;

   // All compares and subtracts run side by side; the chain below only selects.
   assign first_ge_size   = snap.first_value >= resource_size;
   assign last_ge_size    = snap.last_value >= resource_size;
   assign last_lt_first   = snap.last_value < snap.first_value;
   assign size_minus_one  = resource_size - VALUE_W'(1);
   assign size_minus_last = resource_size - snap.last_value;

   always_comb begin
      result.status      = STATUS_OK;
      result.range_first = '0;
      result.range_last  = '0;
      priority if (snap.comma_seen) begin
         result.status = STATUS_MULTI;
      end else if (!snap.prefix_done || snap.invalid_seen || resource_size == '0
                   || !snap.seen_dash) begin
         result.status = STATUS_UNSAT;
      end else if (!snap.first_present) begin
         if (!snap.last_present || snap.last_value == '0) begin
            result.status = STATUS_UNSAT;
         end else begin
            // A suffix longer than the file covers the whole file.
            result.range_first = last_ge_size ? '0 : size_minus_last;
            result.range_last  = size_minus_one;
         end
      end else if (first_ge_size) begin
         result.status = STATUS_UNSAT;
      end else if (!snap.last_present) begin
         result.range_first = snap.first_value;
         result.range_last  = size_minus_one;
      end else if (last_lt_first) begin
         result.status = STATUS_UNSAT;
      end else begin
         result.range_first = snap.first_value;
         result.range_last  = last_ge_size ? size_minus_one : snap.last_value;
      end
   end

endmodule
